>>> src/sha_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

  typedef enum logic [1:0] {
    ACT_ABSORB  = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_e;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

>>> src/sha_cmd_fifo.sv
// short command queue between the input front and the hashing back end
module sha_cmd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sha_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output sha_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;

  assign full_o     = (count_q == (AW+1)'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !empty_o)
    else $error("fifo full and empty at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("fifo filled without a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("fifo drained without a pop");

endmodule

>>> src/sha_core.sv
// back end: block buffer, message state, round engine and digest output
module sha_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  sha_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   digest_word_o,
  output logic [2:0]    word_index_o,
  output logic          last_word_o
);

  sha_pkg::core_state_e state_q, state_d;

  // block buffer as sixteen big-endian words, one byte lane written per absorb
  logic [31:0] buf_q [16];
  logic [6:0]  cnt_q;          // bytes pending, 0..63 between items
  logic [63:0] len_q;
  logic [31:0] cv_q [8];
  logic [31:0] hw_q [8];       // working chaining value of the block in flight
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic        fin_q;          // compression belongs to a finish
  logic        second_q;       // finish block index
  logic        two_q;          // finish needs two blocks
  logic [5:0]  rem_q;
  logic [63:0] bits_q;
  logic [2:0]  oidx_q;

  // load phase: block bytes presented word by word during rounds 0..15
  logic [31:0] blk_word;
  logic [31:0] w_new, w_cur;
  logic [31:0] t1, t2;

  function automatic logic [7:0] tail_byte(input logic [6:0] pos, input logic [7:0] stored);
    logic [7:0] b;
    b = 8'h00;
    if (pos[5:0] < rem_q && pos[6] == 1'b0) b = stored;
    if (pos[6:0] == {1'b0, rem_q}) b = sha_pkg::PAD_BYTE;
    if ((two_q && pos >= 7'd120) || (!two_q && pos >= 7'd56 && pos < 7'd64))
      b = bits_q[8*(7 - pos[2:0]) +: 8];
    return b;
  endfunction

  always_comb begin
    logic [6:0]  base;
    logic [31:0] buf_word;
    base     = {second_q, rnd_q[3:0], 2'b00};
    buf_word = buf_q[rnd_q[3:0]];
    if (fin_q) begin
      blk_word = {tail_byte(base, buf_word[31:24]), tail_byte(base + 7'd1, buf_word[23:16]),
                  tail_byte(base + 7'd2, buf_word[15:8]), tail_byte(base + 7'd3, buf_word[7:0])};
    end else begin
      blk_word = buf_word;
    end
    w_new = w_q[rnd_q[3:0]] + sha_pkg::small_sig0(w_q[rnd_q[3:0] + 4'd1])
          + w_q[rnd_q[3:0] + 4'd9] + sha_pkg::small_sig1(w_q[rnd_q[3:0] + 4'd14]);
    w_cur = (rnd_q < 6'd16) ? blk_word : w_new;
    t1 = v_q[7] + sha_pkg::big_sig1(v_q[4])
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + sha_pkg::ROUND_K[rnd_q] + w_cur;
    t2 = sha_pkg::big_sig0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sha_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.action == sha_pkg::ACT_FINISH) state_d = sha_pkg::ST_ROUND;
          else if (cmd_i.action == sha_pkg::ACT_ABSORB && cnt_q == 7'd63)
            state_d = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!fin_q) state_d = sha_pkg::ST_IDLE;
        else if (two_q && !second_q) state_d = sha_pkg::ST_ROUND;
        else state_d = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_EMIT: if (out_ready_i && oidx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == sha_pkg::ST_EMIT);
  assign digest_word_o = hw_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (state_q == sha_pkg::ST_IDLE && cmd_valid_i
        && cmd_i.action == sha_pkg::ACT_ABSORB) begin
      buf_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= cmd_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sha_pkg::ST_IDLE && cmd_valid_i) begin
      rnd_q    <= '0;
      second_q <= 1'b0;
      fin_q    <= (cmd_i.action == sha_pkg::ACT_FINISH);
      rem_q    <= cnt_q[5:0];
      two_q    <= (cnt_q[5:0] >= 6'd56);
      bits_q   <= {len_q[60:0], 3'b000};
      hw_q     <= cv_q;
      v_q      <= cv_q;
    end else if (state_q == sha_pkg::ST_ROUND) begin
      rnd_q          <= rnd_q + 6'd1;
      w_q[rnd_q[3:0]] <= w_cur;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (state_q == sha_pkg::ST_ADD) begin
      for (int i = 0; i < 8; i++) begin
        hw_q[i] <= hw_q[i] + v_q[i];
        v_q[i]  <= hw_q[i] + v_q[i];
      end
      rnd_q    <= '0;
      second_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      len_q  <= '0;
      oidx_q <= '0;
      cv_q   <= sha_pkg::INIT_HASH;
    end else begin
      if (state_q == sha_pkg::ST_IDLE && cmd_valid_i) begin
        oidx_q <= '0;
        if (cmd_i.action == sha_pkg::ACT_ABSORB) begin
          cnt_q <= (cnt_q == 7'd63) ? 7'd0 : cnt_q + 7'd1;
          len_q <= len_q + 64'd1;
        end else if (cmd_i.action == sha_pkg::ACT_RESTART) begin
          cnt_q <= '0;
          len_q <= '0;
          cv_q  <= sha_pkg::INIT_HASH;
        end
      end
      if (state_q == sha_pkg::ST_ADD && !fin_q) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= hw_q[i] + v_q[i];
      end
      if (state_q == sha_pkg::ST_EMIT && out_ready_i) oidx_q <= oidx_q + 3'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pkg::ST_EMIT) |-> fin_q)
    else $error("digest emitted outside a finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == sha_pkg::ST_IDLE))
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pkg::ST_ROUND && rnd_q == 6'd63) |=> (state_q == sha_pkg::ST_ADD))
    else $error("round count overrun");

endmodule

>>> src/sha256_stream_hasher_top.sv
// top level: streaming sha-256 hasher with command queue and round engine
// absorb: one transfer per cycle into the queue while it is not full; every 64th byte starts a block compression
// finish: the first padded block is compressed, then a second one when the tail needs it, then eight digest transfers
// throughput is set by the single shared round unit, one round per cycle
// restart and absorb otherwise retire from the queue without a compression
// reset: asynchronous, loads the initial hash value and clears counts and queue
module sha256_stream_hasher_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] action, [9:2] data_byte, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::cmd_t in_cmd, q_cmd;
  logic full, empty, pop;
  logic [31:0] dw;
  logic [2:0]  wi;

  assign in_cmd.action    = sha_pkg::action_e'(s_axis_tdata[1:0]);
  assign in_cmd.data_byte = s_axis_tdata[9:2];
  assign s_axis_tready    = !full;

  sha_cmd_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid), .push_data_i(in_cmd), .full_o(full),
    .pop_i(pop), .pop_data_o(q_cmd), .empty_o(empty)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .cmd_valid_i(!empty), .cmd_i(q_cmd), .cmd_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .digest_word_o(dw), .word_index_o(wi), .last_word_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, wi, dw};

endmodule
